// ===== hdl/omw_pkg.sv =====
// ----------------------------------------------------------------------------
// omw_pkg
// Shared types and constants of the four-wheel omni mixer with brake hold.
// ----------------------------------------------------------------------------
`default_nettype none

package omw_pkg;

  localparam int DefMaxScaleSteps = 256;
  localparam int DefCountsPerTurn = 8191;

  localparam int SumW   = 34;
  localparam int MagW   = 32;
  localparam int ScaleW = 17;
  localparam int ProdW  = MagW + ScaleW;
  localparam int BoundW = 46;
  localparam int TgtW   = 32;

  localparam logic signed [15:0] KQ15          = 16'sd23170;
  localparam logic [12:0]        AngleInvalid  = 13'd8191;
  localparam logic [14:0]        SpeedLimitRst = 15'd4000;
  localparam logic [15:0]        ScaleStepRst  = 16'd64225;
  localparam logic [ScaleW-1:0]  ScaleOne      = 17'h10000;

  typedef enum logic [0:0] {
    CfgSpeedLimit = 1'b0,
    CfgScaleStep  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StMult,
    StAdd,
    StLoop,
    StDone
  } omw_state_e;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] spin_rate;
    logic [12:0]        enc_angle_1;
    logic [12:0]        enc_angle_2;
    logic [12:0]        enc_angle_3;
    logic [12:0]        enc_angle_4;
    logic signed [15:0] enc_turns_1;
    logic signed [15:0] enc_turns_2;
    logic signed [15:0] enc_turns_3;
    logic signed [15:0] enc_turns_4;
  } in_item_t;

  typedef struct packed {
    logic               hold_mode;
    logic signed [31:0] wheel_target_1;
    logic signed [31:0] wheel_target_2;
    logic signed [31:0] wheel_target_3;
    logic signed [31:0] wheel_target_4;
  } out_item_t;

  typedef struct packed {
    logic load_sum;
    logic load_prod;
  } lane_ctrl_t;

  typedef struct packed {
    logic over;
    logic zero;
  } lane_stat_t;

  typedef struct packed {
    logic load_pos;
    logic finish;
  } mrg_ctrl_t;

  typedef struct packed {
    logic any_over;
    logic slot_free;
  } mrg_stat_t;

endpackage

`default_nettype wire

// ===== hdl/omw_if.sv =====
// ----------------------------------------------------------------------------
// omw_in_if / omw_out_if
// Valid/ready channels carrying command beats in and result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface omw_in_if import omw_pkg::*; ;
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface omw_out_if import omw_pkg::*; ;
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== hdl/omw_lane.sv =====
// ----------------------------------------------------------------------------
// omw_lane
// One wheel: signed mix of the command, magnitude, scaled limit test and
// truncated speed target.
// ----------------------------------------------------------------------------
`default_nettype none

module omw_lane import omw_pkg::*; #(
  parameter bit NEG_X = 1'b0,
  parameter bit NEG_Y = 1'b0
) (
  input  wire logic                     clk_i,
  input  wire logic signed [31:0]       kx_i,
  input  wire logic signed [31:0]       ky_i,
  input  wire logic signed [15:0]       spin_i,
  input  wire logic [ScaleW-1:0]        scale_i,
  input  wire logic [BoundW-1:0]        bound_i,
  input  wire lane_ctrl_t               ctrl_i,
  output lane_stat_t                    stat_o,
  output logic signed [TgtW-1:0]        target_o
);

  logic signed [SumW-1:0] kx_e, ky_e, sp_e, w_d;
  logic [MagW-1:0]        mag_d, mag_q;
  logic                   neg_q, zero_q;
  logic [ProdW-1:0]       prod_d, prod_q;
  logic [ProdW-31-1:0]    m;

  always_comb begin
    kx_e  = NEG_X ? -SumW'(kx_i) : SumW'(kx_i);
    ky_e  = NEG_Y ? -SumW'(ky_i) : SumW'(ky_i);
    sp_e  = SumW'(spin_i) <<< 15;
    w_d   = kx_e + ky_e + sp_e;
    mag_d = w_d[SumW-1] ? MagW'(-w_d) : MagW'(w_d);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_sum) begin
      mag_q  <= mag_d;
      neg_q  <= w_d[SumW-1];
      zero_q <= (w_d == '0);
    end
    if (ctrl_i.load_prod) begin
      prod_q <= prod_d;
    end
  end

  assign prod_d      = ProdW'(mag_q) * ProdW'(scale_i);
  assign stat_o.over = prod_d > ProdW'(bound_i);
  assign stat_o.zero = zero_q;

  assign m        = prod_q[ProdW-1:31];
  assign target_o = neg_q ? -TgtW'(m) : TgtW'(m);

endmodule

`default_nettype wire

// ===== hdl/omw_merge.sv =====
// ----------------------------------------------------------------------------
// omw_merge
// Combine lane flags, latch hold positions and register the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module omw_merge import omw_pkg::*; #(
  parameter int COUNTS_PER_TURN = DefCountsPerTurn
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire mrg_ctrl_t                  ctrl_i,
  output mrg_stat_t                       stat_o,
  input  wire logic [3:0][12:0]           angle_i,
  input  wire logic [3:0][15:0]           turns_i,
  input  wire lane_stat_t [3:0]           lane_i,
  input  wire logic [3:0][TgtW-1:0]       target_i,
  output logic                            out_valid_o,
  output out_item_t                       out_item_o,
  input  wire logic                       out_ready_i
);

  localparam logic [16:0] CptU = 17'(COUNTS_PER_TURN);

  logic [3:0][31:0] pos_d, pos_q, held_d, held_q, res;
  logic             pos_ok_d, pos_ok_q;
  logic             latched_q;
  logic             all_zero, load_new;
  logic             out_valid_q;
  out_item_t        out_item_q;
  logic signed [33:0] tp [4];

  always_comb begin
    pos_ok_d = 1'b1;
    for (int i = 0; i < 4; i++) begin
      tp[i]    = $signed(turns_i[i]) * $signed({1'b0, CptU});
      pos_d[i] = tp[i][31:0] + 32'(angle_i[i]);
      if (angle_i[i] == AngleInvalid) pos_ok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_pos) begin
      pos_q    <= pos_d;
      pos_ok_q <= pos_ok_d;
    end
  end

  always_comb begin
    all_zero = 1'b1;
    stat_o.any_over = 1'b0;
    for (int i = 0; i < 4; i++) begin
      all_zero        = all_zero & lane_i[i].zero;
      stat_o.any_over = stat_o.any_over | lane_i[i].over;
    end
    stat_o.slot_free = !out_valid_q || out_ready_i;
    load_new = all_zero && !latched_q && pos_ok_q;
    held_d   = load_new ? pos_q : held_q;
    res      = all_zero ? held_d : target_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q   <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.finish) begin
        latched_q   <= all_zero;
        held_q      <= held_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      out_item_q.hold_mode      <= all_zero;
      out_item_q.wheel_target_1 <= res[0];
      out_item_q.wheel_target_2 <= res[1];
      out_item_q.wheel_target_3 <= res[2];
      out_item_q.wheel_target_4 <= res[3];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== hdl/omni_wheel_mixer_with_brake_hold.sv =====
// ----------------------------------------------------------------------------
// omni_wheel_mixer_with_brake_hold
// Four-wheel omni drive mixer: four wheel lanes scale the command under a
// speed limit, a merge stage picks speed targets or latched hold positions.
//
//   channel   dir  handshake          beat
//   in_if     in   valid/ready        velocity command + four encoders
//   out_if    out  valid/ready        hold_mode + four wheel targets
//   cfg       in   cfg_we_i           speed_limit (0), scale_step (1)
//
// An item passes StMult, StAdd, StLoop and StDone from accept to result, with s
// scale steps (0 to MAX_SCALE_STEPS) in StLoop; the scale loop runs one step a
// cycle through the lane multipliers. One item is in work at a time; the next
// beat is taken the cycle after the result is loaded, while the result may still
// wait. A stalled output holds the loop at its last stage. Reset clears the hold
// latch, the held positions and the registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module omni_wheel_mixer_with_brake_hold import omw_pkg::*; #(
  parameter int MAX_SCALE_STEPS = DefMaxScaleSteps,
  parameter int COUNTS_PER_TURN = DefCountsPerTurn
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  omw_in_if.sink           in_if,
  omw_out_if.source        out_if,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  localparam int StepW = $clog2(MAX_SCALE_STEPS + 1);

  omw_state_e state_q, state_d;

  logic [14:0]          speed_limit_q;
  logic [15:0]          scale_step_q;
  in_item_t             in_q;
  logic signed [31:0]   kx_q, ky_q;
  logic [ScaleW-1:0]    scale_q;
  logic [StepW-1:0]     steps_q;
  logic [ScaleW+16-1:0] scale_prod;
  logic [BoundW-1:0]    bound;
  logic                 accept, cap_hit;

  logic                 load_k, init_scale, step_scale;
  lane_ctrl_t           lane_ctrl;
  mrg_ctrl_t            mrg_ctrl;
  mrg_stat_t            mrg_stat;
  lane_stat_t [3:0]     lane_stat;
  logic [3:0][TgtW-1:0] target;

  assign accept     = in_if.valid && in_if.ready;
  assign cap_hit    = (steps_q == StepW'(MAX_SCALE_STEPS));
  assign bound      = {speed_limit_q, 31'b0};
  assign scale_prod = (ScaleW + 16)'(scale_q) * (ScaleW + 16)'(scale_step_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept) state_d = StMult;
      StMult: state_d = StAdd;
      StAdd:  state_d = StLoop;
      StLoop: if (cap_hit || !mrg_stat.any_over) state_d = StDone;
      StDone: if (mrg_stat.slot_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_if.ready         = 1'b0;
    load_k              = 1'b0;
    init_scale          = 1'b0;
    step_scale          = 1'b0;
    lane_ctrl           = '0;
    mrg_ctrl            = '0;
    unique case (state_q)
      StIdle: in_if.ready = 1'b1;
      StMult: begin
        load_k            = 1'b1;
        mrg_ctrl.load_pos = 1'b1;
      end
      StAdd: begin
        lane_ctrl.load_sum = 1'b1;
        init_scale         = 1'b1;
      end
      StLoop: begin
        lane_ctrl.load_prod = 1'b1;
        step_scale          = !cap_hit && mrg_stat.any_over;
      end
      StDone: mrg_ctrl.finish = mrg_stat.slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      speed_limit_q <= SpeedLimitRst;
      scale_step_q  <= ScaleStepRst;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CfgSpeedLimit: speed_limit_q <= cfg_wdata_i[14:0];
          CfgScaleStep:  scale_step_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_if.item;
    if (load_k) begin
      kx_q <= in_q.vel_x * KQ15;
      ky_q <= in_q.vel_y * KQ15;
    end
    if (init_scale) begin
      scale_q <= ScaleOne;
      steps_q <= '0;
    end else if (step_scale) begin
      scale_q <= scale_prod[ScaleW+16-1:16];
      steps_q <= steps_q + StepW'(1);
    end
  end

  omw_lane #(.NEG_X(1'b0), .NEG_Y(1'b1)) u_lane_1 (
    .clk_i, .kx_i(kx_q), .ky_i(ky_q), .spin_i(in_q.spin_rate), .scale_i(scale_q),
    .bound_i(bound), .ctrl_i(lane_ctrl), .stat_o(lane_stat[0]), .target_o(target[0])
  );
  omw_lane #(.NEG_X(1'b0), .NEG_Y(1'b0)) u_lane_2 (
    .clk_i, .kx_i(kx_q), .ky_i(ky_q), .spin_i(in_q.spin_rate), .scale_i(scale_q),
    .bound_i(bound), .ctrl_i(lane_ctrl), .stat_o(lane_stat[1]), .target_o(target[1])
  );
  omw_lane #(.NEG_X(1'b1), .NEG_Y(1'b0)) u_lane_3 (
    .clk_i, .kx_i(kx_q), .ky_i(ky_q), .spin_i(in_q.spin_rate), .scale_i(scale_q),
    .bound_i(bound), .ctrl_i(lane_ctrl), .stat_o(lane_stat[2]), .target_o(target[2])
  );
  omw_lane #(.NEG_X(1'b1), .NEG_Y(1'b1)) u_lane_4 (
    .clk_i, .kx_i(kx_q), .ky_i(ky_q), .spin_i(in_q.spin_rate), .scale_i(scale_q),
    .bound_i(bound), .ctrl_i(lane_ctrl), .stat_o(lane_stat[3]), .target_o(target[3])
  );

  omw_merge #(.COUNTS_PER_TURN(COUNTS_PER_TURN)) u_merge (
    .clk_i,
    .rst_ni,
    .ctrl_i      (mrg_ctrl),
    .stat_o      (mrg_stat),
    .angle_i     ({in_q.enc_angle_4, in_q.enc_angle_3, in_q.enc_angle_2,
                   in_q.enc_angle_1}),
    .turns_i     ({in_q.enc_turns_4, in_q.enc_turns_3, in_q.enc_turns_2,
                   in_q.enc_turns_1}),
    .lane_i      (lane_stat),
    .target_i    (target),
    .out_valid_o (out_if.valid),
    .out_item_o  (out_if.item),
    .out_ready_i (out_if.ready)
  );

endmodule

`default_nettype wire

// ===== hdl/omw_chk.sv =====
// ----------------------------------------------------------------------------
// omw_chk
// Port-level checks of the omni mixer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module omw_chk import omw_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_i,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_i
);

  logic tgt_ok;

  always_comb begin
    tgt_ok = (out_item_i.wheel_target_1[31:18] == '0 ||
              out_item_i.wheel_target_1[31:18] == '1) &&
             (out_item_i.wheel_target_2[31:18] == '0 ||
              out_item_i.wheel_target_2[31:18] == '1) &&
             (out_item_i.wheel_target_3[31:18] == '0 ||
              out_item_i.wheel_target_3[31:18] == '1) &&
             (out_item_i.wheel_target_4[31:18] == '0 ||
              out_item_i.wheel_target_4[31:18] == '1);
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready stayed high after an accepted beat");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result beat appeared without an item in work");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.hold_mode |-> tgt_ok)
    else $error("speed target outside the scaled range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("stalled result beat changed");

endmodule

bind omni_wheel_mixer_with_brake_hold omw_chk u_omw_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_item_i  (out_if.item)
);

`default_nettype wire

// ===== tb/tb_omni_wheel_mixer_with_brake_hold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_omni_wheel_mixer_with_brake_hold
// Self-checking bench for the omni wheel mixer. Command beats come from a
// queue through a clocked driver with random gaps, and result beats are
// taken with random stalls and one long hold-off. Each accepted command is
// mixed by a behavioral model of the wheel sums, the scale loop and the
// brake hold latch. Each result is compared field by field with the oldest
// predicted target. Directed corner cases run first, then random phases
// under several speed limit and scale step settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_omni_wheel_mixer_with_brake_hold;
  import omw_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int EndSettle     = 300;
  localparam int PhaseItems    = 125;
  localparam int ParkCycles    = 400;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  cfg_reg_e cfg_idx;
  logic [15:0] cfg_wdata;

  omw_in_if  cmd_bus ();
  omw_out_if res_bus ();

  omni_wheel_mixer_with_brake_hold dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (cmd_bus),
    .out_if     (res_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // model state and register copies
  logic [14:0]        lim_reg = SpeedLimitRst;
  logic [15:0]        step_reg = ScaleStepRst;
  logic               brake_latched = 1'b0;
  logic signed [31:0] brake_pos [4] = '{default: '0};

  in_item_t  cmd_q [$];
  out_item_t target_q [$];

  int  queued = 0;
  int  res_count = 0;
  int  errors = 0;
  int  idle_cycles = 0;
  int  park_cnt = 0;
  int  src_wait = 0;
  int  snk_wait = 0;
  bit  cmd_taken = 1'b0;
  bit  res_taken = 1'b0;
  bit  quiet = 1'b0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint unsigned wheel_mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic out_item_t mix_command(in_item_t c);
    longint             vx, vy, sp, kx, ky, pos, t;
    longint             w [4];
    longint unsigned    sc, bound, m;
    logic [12:0]        ang [4];
    logic signed [15:0] trn [4];
    logic signed [31:0] tgt [4];
    logic               over, enc_ok;
    out_item_t          r;
    vx = longint'(c.vel_x);
    vy = longint'(c.vel_y);
    sp = longint'(c.spin_rate) * 32768;
    kx = longint'(KQ15) * vx;
    ky = longint'(KQ15) * vy;
    w[0] = kx - ky + sp;
    w[1] = kx + ky + sp;
    w[2] = -kx + ky + sp;
    w[3] = -kx - ky + sp;
    sc = ScaleOne;
    bound = longint'(lim_reg) << 31;
    for (int steps = 0; steps < DefMaxScaleSteps; steps++) begin
      over = 1'b0;
      foreach (w[i]) if (wheel_mag(w[i]) * sc > bound) over = 1'b1;
      if (!over) break;
      sc = (sc * step_reg) >> 16;
    end
    ang = '{c.enc_angle_1, c.enc_angle_2, c.enc_angle_3, c.enc_angle_4};
    trn = '{c.enc_turns_1, c.enc_turns_2, c.enc_turns_3, c.enc_turns_4};
    if (w[0] == 0 && w[1] == 0 && w[2] == 0 && w[3] == 0) begin
      if (!brake_latched) begin
        enc_ok = 1'b1;
        foreach (ang[i]) if (ang[i] >= AngleInvalid) enc_ok = 1'b0;
        if (enc_ok) begin
          foreach (ang[i]) begin
            pos = longint'(ang[i]) + longint'(trn[i]) * DefCountsPerTurn;
            brake_pos[i] = pos[31:0];
          end
        end
      end
      brake_latched = 1'b1;
      r.hold_mode = 1'b1;
      tgt = brake_pos;
    end else begin
      brake_latched = 1'b0;
      r.hold_mode = 1'b0;
      foreach (w[i]) begin
        m = (wheel_mag(w[i]) * sc) >> 31;
        t = (w[i] < 0) ? -longint'(m) : longint'(m);
        tgt[i] = t[31:0];
      end
    end
    r.wheel_target_1 = tgt[0];
    r.wheel_target_2 = tgt[1];
    r.wheel_target_3 = tgt[2];
    r.wheel_target_4 = tgt[3];
    return r;
  endfunction

  function automatic int pause_len();
    return quiet ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic in_item_t with_cmd(logic signed [15:0] vx, logic signed [15:0] vy,
                                        logic signed [15:0] sp);
    in_item_t c;
    c.vel_x = vx;
    c.vel_y = vy;
    c.spin_rate = sp;
    c.enc_angle_1 = 13'($urandom_range(0, 8190));
    c.enc_angle_2 = 13'($urandom_range(0, 8190));
    c.enc_angle_3 = 13'($urandom_range(0, 8190));
    c.enc_angle_4 = 13'($urandom_range(0, 8190));
    c.enc_turns_1 = 16'($urandom);
    c.enc_turns_2 = 16'($urandom);
    c.enc_turns_3 = 16'($urandom);
    c.enc_turns_4 = 16'($urandom);
    return c;
  endfunction

  function automatic in_item_t spoil_angle(in_item_t c);
    in_item_t r;
    r = c;
    case ($urandom_range(0, 3))
      0: r.enc_angle_1 = AngleInvalid;
      1: r.enc_angle_2 = AngleInvalid;
      2: r.enc_angle_3 = AngleInvalid;
      default: r.enc_angle_4 = AngleInvalid;
    endcase
    return r;
  endfunction

  function automatic in_item_t drive_cmd();
    int k;
    k = $urandom_range(0, 3);
    case (k)
      1: return with_cmd(16'($urandom_range(0, 600) - 300),
                         16'($urandom_range(0, 600) - 300),
                         16'($urandom_range(0, 600) - 300));
      2: begin
        case ($urandom_range(0, 2))
          0: return with_cmd(16'($urandom), 0, 0);
          1: return with_cmd(0, 16'($urandom), 0);
          default: return with_cmd(0, 0, 16'($urandom));
        endcase
      end
      default: return with_cmd(16'($urandom), 16'($urandom), 16'($urandom));
    endcase
  endfunction

  task automatic send(in_item_t c);
    cmd_q.push_back(c);
    queued++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (res_count != queued) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgSpeedLimit) lim_reg = val[14:0];
    else step_reg = val;
  endtask

  task automatic set_regs(logic [15:0] lim, logic [15:0] step);
    drain();
    cfg_write(CfgSpeedLimit, lim);
    cfg_write(CfgScaleStep, step);
  endtask

  // predict on every accepted command beat
  always @(posedge clk_i) begin
    if (rst_ni && cmd_bus.valid && cmd_bus.ready) begin
      target_q.push_back(mix_command(cmd_bus.item));
      cmd_taken = 1'b1;
    end
  end

  always @(posedge clk_i) begin : res_check
    out_item_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      res_taken = 1'b1;
      res_count++;
      if (target_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        want = target_q.pop_front();
        if (res_bus.item.hold_mode !== want.hold_mode ||
            res_bus.item.wheel_target_1 !== want.wheel_target_1 ||
            res_bus.item.wheel_target_2 !== want.wheel_target_2 ||
            res_bus.item.wheel_target_3 !== want.wheel_target_3 ||
            res_bus.item.wheel_target_4 !== want.wheel_target_4) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch on result %0d: expected hold=%0d %0d %0d %0d %0d",
                     res_count, want.hold_mode, want.wheel_target_1,
                     want.wheel_target_2, want.wheel_target_3, want.wheel_target_4);
            $display("  actual hold=%0d %0d %0d %0d %0d",
                     res_bus.item.hold_mode, res_bus.item.wheel_target_1,
                     res_bus.item.wheel_target_2, res_bus.item.wheel_target_3,
                     res_bus.item.wheel_target_4);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin : cmd_driver
    logic v_next;
    v_next = cmd_bus.valid;
    if (cmd_taken) begin
      cmd_taken = 1'b0;
      v_next = 1'b0;
      src_wait = pause_len();
    end
    if (!v_next && rst_ni) begin
      if (src_wait > 0) begin
        src_wait--;
      end else if (cmd_q.size() > 0) begin
        cmd_bus.item <= cmd_q.pop_front();
        v_next = 1'b1;
      end
    end
    cmd_bus.valid <= v_next;
  end

  always @(negedge clk_i) begin
    if (res_taken) begin
      res_taken = 1'b0;
      snk_wait = pause_len();
    end else if (snk_wait > 0) begin
      snk_wait--;
    end
    res_bus.ready <= rst_ni && snk_wait == 0 && park_cnt == 0;
  end

  always @(posedge clk_i) begin
    if (park_cnt > 0) park_cnt <= park_cnt - 1;
  end

  always @(posedge clk_i) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL omni_wheel_mixer_with_brake_hold");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    in_item_t c;
    logic [15:0] lims [8];
    logic [15:0] steps [8];
    int n;
    int len;
    cmd_bus.valid = 1'b0;
    cmd_bus.item = '0;
    res_bus.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgSpeedLimit;
    cfg_wdata = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values: brake hold entry, continuation and the velocity extremes
    c = spoil_angle(with_cmd(0, 0, 0));
    send(c);
    send(with_cmd(32767, 32767, 32767));
    send(with_cmd(0, 0, 0));
    send(spoil_angle(with_cmd(0, 0, 0)));
    send(with_cmd(-32768, -32768, -32768));
    send(spoil_angle(with_cmd(0, 0, 0)));
    send(with_cmd(32767, -32768, 0));
    c = with_cmd(0, 0, 0);
    c.enc_angle_1 = 13'd8190;
    c.enc_angle_2 = 13'd8190;
    c.enc_angle_3 = 13'd8190;
    c.enc_angle_4 = 13'd8190;
    c.enc_turns_1 = 16'sd32767;
    c.enc_turns_2 = -16'sd32768;
    c.enc_turns_3 = 16'sd32767;
    c.enc_turns_4 = -16'sd32768;
    send(c);
    send(with_cmd(0, 0, 32767));
    send(with_cmd(0, 0, -32768));
    send(with_cmd(1, 0, 0));
    send(with_cmd(0, -1, 0));
    send(with_cmd(0, 0, 1));
    c = with_cmd(0, 0, 0);
    c.enc_angle_1 = '0;
    c.enc_angle_2 = '0;
    c.enc_angle_3 = '0;
    c.enc_angle_4 = '0;
    c.enc_turns_1 = -16'sd1;
    c.enc_turns_2 = -16'sd1;
    c.enc_turns_3 = -16'sd1;
    c.enc_turns_4 = -16'sd1;
    send(c);

    // zero speed limit
    set_regs(16'd0, ScaleStepRst);
    send(with_cmd(1000, -2000, 300));
    send(with_cmd(1, 1, 1));
    // zero scale step, hold decided on the unscaled sums
    set_regs(16'd4000, 16'd0);
    send(with_cmd(5000, 7, -9));
    send(with_cmd(0, 0, 0));
    // widest limit and step
    set_regs(16'd32767, 16'd65535);
    send(with_cmd(32767, 0, 32767));
    send(with_cmd(100, 100, 100));
    // step cap reached before the limit is met
    set_regs(16'd1, 16'd65535);
    send(with_cmd(20000, -20000, 5));

    lims  = '{16'd4000, 16'd1, 16'd32767, 16'd100, 16'($urandom_range(1, 32767)),
              16'd4000, 16'd20000, 16'($urandom_range(1, 32767))};
    steps = '{16'd64225, 16'd65535, 16'd32768, 16'd60000, 16'($urandom_range(0, 65535)),
              16'd1, 16'd64225, 16'($urandom_range(0, 65535))};
    for (int ph = 0; ph < 8; ph++) begin
      set_regs(lims[ph], steps[ph]);
      quiet = (ph == 5);
      n = 0;
      while (n < PhaseItems) begin
        len = $urandom_range(1, 6);
        if ($urandom_range(0, 3) == 0) begin
          repeat ((len + 1) / 2) begin
            c = with_cmd(0, 0, 0);
            if ($urandom_range(0, 4) == 0) c = spoil_angle(c);
            send(c);
            n++;
          end
        end else begin
          repeat (len) begin
            send(drive_cmd());
            n++;
          end
        end
      end
      if (ph == 6) park_cnt <= ParkCycles;
    end

    drain();
    repeat (EndSettle) @(negedge clk_i);
    if (errors == 0 && target_q.size() == 0) begin
      $display("PASS omni_wheel_mixer_with_brake_hold");
    end else begin
      $display("FAIL omni_wheel_mixer_with_brake_hold");
    end
    $finish;
  end

endmodule

`default_nettype wire
